// ----- rtl/core/mbe_pkg.sv -----
package mbe_pkg;

	// Default coordinate format: Q3.28 in a 32-bit word
	localparam int COORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 28;

	// Iteration counter and limit register
	localparam int                ITER_W       = 16;
	localparam logic [ITER_W-1:0] MAX_ITER_RST = 16'd256;

	// Widest single multiply the shared unit performs per cycle
	localparam int LIMB_MAX = 32;

endpackage

// ----- rtl/core/mbe_mul.sv -----
// Shared saturating fixed-point multiplier.
// Works on magnitudes split into limbs of at most LIMB_MAX bits; one limb
// product per cycle, registered, then shifted into a wide accumulator.
// The result is truncated toward zero by FRAC_BITS and saturated to the
// signed coordinate range. done pulses for one cycle; prod holds after it.
module mbe_mul
	import mbe_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [COORD_BITS-1:0] a,
	input  logic signed [COORD_BITS-1:0] b,
	output logic                         done,
	output logic signed [COORD_BITS-1:0] prod
);

	localparam int NL = (COORD_BITS + LIMB_MAX - 1) / LIMB_MAX;
	localparam int LW = (COORD_BITS + NL - 1) / NL;
	localparam int MW = NL * LW;
	localparam int PW = 2 * MW;
	localparam int IW = (NL > 1) ? $clog2(NL) : 1;
	localparam int SW = IW + 1;

	localparam logic [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic [IW-1:0]         LAST_LIMB = IW'(NL - 1);

	logic [COORD_BITS-1:0] mag_a, mag_b;
	logic [MW-1:0]         ma_q, mb_q;
	logic                  neg_q;
	logic [IW-1:0]         ia_q, ib_q;
	logic                  issue_q;
	logic                  issue_last;
	logic [2*LW-1:0]       pp_s1;
	logic [SW-1:0]         sh_s1;
	logic                  pv_s1, lst_s1;
	logic [PW-1:0]         acc_q;
	logic                  fin_q;
	logic                  done_q;
	logic [COORD_BITS-1:0] prod_q;

	logic [PW-1:0]         q_full;
	logic [COORD_BITS-1:0] limit;
	logic                  over;
	logic [COORD_BITS-1:0] q_sat;

	// Operand magnitudes; the most negative value maps to 2^(N-1)
	assign mag_a = a[COORD_BITS-1] ? (~a + 1'b1) : a;
	assign mag_b = b[COORD_BITS-1] ? (~b + 1'b1) : b;

	assign issue_last = (ia_q == LAST_LIMB) && (ib_q == LAST_LIMB);

	// Truncate, saturate against the sign-dependent limit
	assign q_full = acc_q >> FRAC_BITS;
	assign limit  = CMAX + COORD_BITS'(neg_q);
	assign over   = q_full > PW'(limit);
	assign q_sat  = over ? limit : q_full[COORD_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ma_q    <= '0;
			mb_q    <= '0;
			neg_q   <= 1'b0;
			ia_q    <= '0;
			ib_q    <= '0;
			issue_q <= 1'b0;
			pp_s1   <= '0;
			sh_s1   <= '0;
			pv_s1   <= 1'b0;
			lst_s1  <= 1'b0;
			acc_q   <= '0;
			fin_q   <= 1'b0;
			done_q  <= 1'b0;
			prod_q  <= '0;
		end else begin
			// operand capture
			if (start) begin
				ma_q    <= MW'(mag_a);
				mb_q    <= MW'(mag_b);
				neg_q   <= a[COORD_BITS-1] ^ b[COORD_BITS-1];
				ia_q    <= '0;
				ib_q    <= '0;
				issue_q <= 1'b1;
				acc_q   <= '0;
			end else if (issue_q) begin
				if (issue_last) begin
					issue_q <= 1'b0;
				end else if (ib_q == LAST_LIMB) begin
					ib_q <= '0;
					ia_q <= ia_q + 1'b1;
				end else begin
					ib_q <= ib_q + 1'b1;
				end
			end

			// limb product stage
			pv_s1  <= issue_q && !start;
			lst_s1 <= issue_q && !start && issue_last;
			pp_s1  <= ma_q[ia_q*LW +: LW] * mb_q[ib_q*LW +: LW];
			sh_s1  <= SW'(ia_q) + SW'(ib_q);

			// accumulate
			if (pv_s1) begin
				acc_q <= acc_q + (PW'(pp_s1) << (sh_s1 * LW));
			end
			fin_q <= pv_s1 && lst_s1;

			// final saturation and sign
			done_q <= fin_q;
			if (fin_q) begin
				prod_q <= neg_q ? (~q_sat + 1'b1) : q_sat;
			end
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

// ----- rtl/core/mandelbrot_escape_iterator.sv -----
// Mandelbrot escape-time iterator. Each input word is a point c (c_real,
// c_imag, signed fixed point with FRAC_BITS fraction bits, Q3.28 by default);
// the block iterates z = z*z + c from z = 0 with saturating arithmetic and
// returns, per point, the number of iterations done until |z|^2 reached 4 or
// max_iterations was hit, with last_in copied to last_out. A max_iterations
// of 0 gives a count of 0. One point is worked on at a time through a single
// shared multiplier that does three products per iteration (z_r*z_i, then
// the squares of the new z, which also serve the escape test). in_ready is
// high whenever no point is in flight; a finished count waits in the output
// register without holding up the next point.
// The configuration channel is always ready and should be written only
// while the block is idle.
module mandelbrot_escape_iterator
	import mbe_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ITER_W-1:0]            max_iterations,

	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] c_real,
	input  logic signed [COORD_BITS-1:0] c_imag,
	input  logic                         last_in,

	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ITER_W-1:0]            iteration_count,
	output logic                         last_out
);

	typedef logic signed [COORD_BITS-1:0] coord_t;

	localparam coord_t CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam coord_t ESC_LIM = (FRAC_BITS + 3 >= COORD_BITS) ?
		CMAX : (coord_t'(4) << FRAC_BITS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_RI,
		S_UPD,
		S_MUL_RR,
		S_MUL_II,
		S_CHECK,
		S_OUT
	} state_t;

	state_t              state_q;
	logic [ITER_W-1:0]   max_it_q;
	logic                start_q;
	coord_t              cr_q, ci_q, zr_q, zi_q;
	coord_t              rr_q, ii_q, ri_q;
	logic [ITER_W-1:0]   n_q;
	logic                last_q;
	logic                out_valid_q;
	logic [ITER_W-1:0]   count_q;
	logic                last_out_q;

	coord_t              mul_a, mul_b, mul_prod;
	logic                mul_done;
	coord_t              nr, ni, esc_sum;
	logic                escape;
	logic                in_acc;

	// Saturating add and subtract in the coordinate range
	function automatic coord_t sat_add(input coord_t x, input coord_t y);
		logic signed [COORD_BITS:0] s;
		s = {x[COORD_BITS-1], x} + {y[COORD_BITS-1], y};
		if (s[COORD_BITS] != s[COORD_BITS-1])
			return s[COORD_BITS] ? CMIN : CMAX;
		return s[COORD_BITS-1:0];
	endfunction

	function automatic coord_t sat_sub(input coord_t x, input coord_t y);
		logic signed [COORD_BITS:0] s;
		s = {x[COORD_BITS-1], x} - {y[COORD_BITS-1], y};
		if (s[COORD_BITS] != s[COORD_BITS-1])
			return s[COORD_BITS] ? CMIN : CMAX;
		return s[COORD_BITS-1:0];
	endfunction

	// Shared multiplier
	mbe_mul #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// Operand select for the current product
	always_comb begin
		case (state_q)
			S_MUL_RR: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
			S_MUL_II: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			default: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
		endcase
	end

	// Next z and escape test
	assign nr      = sat_add(sat_sub(rr_q, ii_q), cr_q);
	assign ni      = sat_add(sat_add(ri_q, ri_q), ci_q);
	assign esc_sum = sat_add(rr_q, ii_q);
	assign escape  = esc_sum >= ESC_LIM;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			max_it_q    <= MAX_ITER_RST;
			start_q     <= 1'b0;
			cr_q        <= '0;
			ci_q        <= '0;
			zr_q        <= '0;
			zi_q        <= '0;
			rr_q        <= '0;
			ii_q        <= '0;
			ri_q        <= '0;
			n_q         <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			last_out_q  <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (cfg_valid) begin
				max_it_q <= max_iterations;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cr_q   <= c_real;
						ci_q   <= c_imag;
						last_q <= last_in;
						zr_q   <= '0;
						zi_q   <= '0;
						rr_q   <= '0;
						ii_q   <= '0;
						n_q    <= '0;
						if (max_it_q == '0) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_MUL_RI;
							start_q <= 1'b1;
						end
					end
				end
				S_MUL_RI: begin
					if (mul_done) begin
						ri_q    <= mul_prod;
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					zr_q    <= nr;
					zi_q    <= ni;
					n_q     <= n_q + 1'b1;
					state_q <= S_MUL_RR;
					start_q <= 1'b1;
				end
				S_MUL_RR: begin
					if (mul_done) begin
						rr_q    <= mul_prod;
						state_q <= S_MUL_II;
						start_q <= 1'b1;
					end
				end
				S_MUL_II: begin
					if (mul_done) begin
						ii_q    <= mul_prod;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (escape || (n_q >= max_it_q)) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_MUL_RI;
						start_q <= 1'b1;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						count_q     <= n_q;
						last_out_q  <= last_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign iteration_count = count_q;
	assign last_out        = last_out_q;

	// Squares coming back from the multiplier are never negative
	a_sq_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> (!rr_q[COORD_BITS-1] && !ii_q[COORD_BITS-1]))
		else $error("negative square at escape test");

	// The multiplier only finishes while the sequencer waits for it
	a_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_MUL_RI || state_q == S_MUL_RR ||
			state_q == S_MUL_II))
		else $error("multiplier done outside a product step");

	// A zero limit skips iteration entirely
	a_zero_max: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (max_it_q == '0)) |=> (state_q == S_OUT && n_q == '0))
		else $error("zero limit did not go straight to output");

endmodule
